FILE: src/pkd_pkg.sv
package pkd_pkg;

  localparam int MAX_KEY_DEFAULT = 1024;

  // Parser phase codes.
  localparam logic [2:0] PH_SHARED  = 3'd0;
  localparam logic [2:0] PH_SUFFIX  = 3'd1;
  localparam logic [2:0] PH_VALCODE = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_VALUE   = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_VARINT    = 3'd1;
  localparam logic [2:0] ERR_SHARED    = 3'd2;
  localparam logic [2:0] ERR_KEY       = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [31:0] position;
    logic [10:0] shared_len;
    logic [10:0] suffix_len;
    logic [31:0] value_len;
    logic        is_delete;
    logic [2:0]  error_code;
    logic        record_end;
    logic        block_end;
  } pkd_result_t;

endpackage

FILE: src/pkd_in_stage.sv
module pkd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_data,
  input  logic       s_last,
  input  logic       step,
  output logic       in_valid,
  output logic [7:0] in_data,
  output logic       in_last
);

  // The register frees up in the same cycle the parser consumes it.
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_data;
      in_last <= s_last;
    end
  end

endmodule

FILE: src/pkd_parser.sv
module pkd_parser #(
  parameter int MAX_KEY = pkd_pkg::MAX_KEY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  output logic                res_valid,
  output pkd_pkg::pkd_result_t res
);
  import pkd_pkg::*;

  localparam int KW = $clog2(MAX_KEY + 1);

  logic [2:0]    phase, phase_next;
  logic [31:0]   varint_acc, varint_acc_next;
  logic [2:0]    varint_bytes, varint_bytes_next;
  logic [KW-1:0] cur_shared, cur_shared_next;
  logic [KW-1:0] cur_suffix, cur_suffix_next;
  logic [KW-1:0] remaining, remaining_next;
  logic [31:0]   value_left, value_left_next;
  logic [31:0]   emit_index, emit_index_next;
  logic [KW-1:0] prev_key_len, prev_key_len_next;
  logic          discarding, discarding_next;

  logic [31:0] piece;
  logic [31:0] acc_or;
  logic [2:0]  vb_inc;
  logic [31:0] v;
  logic        del;
  logic [31:0] vlen;
  logic [2:0]  err;
  logic        clear_all;

  always_comb begin
    unique case (varint_bytes)
      3'd0:    piece = 32'(in_data[6:0]);
      3'd1:    piece = 32'(in_data[6:0]) << 7;
      3'd2:    piece = 32'(in_data[6:0]) << 14;
      3'd3:    piece = 32'(in_data[6:0]) << 21;
      3'd4:    piece = 32'(in_data[6:0]) << 28;
      default: piece = '0;
    endcase
  end

  assign acc_or = varint_acc | piece;
  assign vb_inc = varint_bytes + 3'd1;
  assign v      = acc_or;
  assign del    = (v == 32'd0);
  assign vlen   = del ? 32'd0 : v - 32'd1;

  always_comb begin
    phase_next        = phase;
    varint_acc_next   = varint_acc;
    varint_bytes_next = varint_bytes;
    cur_shared_next   = cur_shared;
    cur_suffix_next   = cur_suffix;
    remaining_next    = remaining;
    value_left_next   = value_left;
    emit_index_next   = emit_index;
    prev_key_len_next = prev_key_len;
    discarding_next   = discarding;
    res               = '0;
    res_valid         = 1'b0;
    err               = ERR_NONE;
    clear_all         = 1'b0;

    if (discarding) begin
      clear_all = in_last;
    end else begin
      unique case (phase)
        PH_SHARED, PH_SUFFIX, PH_VALCODE: begin
          if (in_data[7]) begin
            varint_acc_next   = acc_or;
            varint_bytes_next = vb_inc;
            if (vb_inc >= VARINT_MAX_BYTES) begin
              err = ERR_VARINT;
            end
          end else begin
            varint_acc_next   = '0;
            varint_bytes_next = '0;
            if (phase == PH_SHARED) begin
              if (v > 32'(prev_key_len)) begin
                err = ERR_SHARED;
              end else begin
                cur_shared_next = KW'(v);
                phase_next      = PH_SUFFIX;
              end
            end else if (phase == PH_SUFFIX) begin
              if ({1'b0, 32'(cur_shared)} + {1'b0, v} > 33'(MAX_KEY)) begin
                err = ERR_KEY;
              end else begin
                cur_suffix_next = KW'(v);
                phase_next      = PH_VALCODE;
              end
            end else begin
              res_valid         = 1'b1;
              res.kind          = KIND_HEADER;
              res.shared_len    = 11'(cur_shared);
              res.suffix_len    = 11'(cur_suffix);
              res.value_len     = vlen;
              res.is_delete     = del;
              value_left_next   = vlen;
              prev_key_len_next = cur_shared + cur_suffix;
              remaining_next    = cur_suffix;
              emit_index_next   = '0;
              if (cur_suffix != '0) begin
                phase_next = PH_KEY;
              end else if (vlen != 32'd0) begin
                phase_next = PH_VALUE;
              end else begin
                phase_next     = PH_SHARED;
                res.record_end = 1'b1;
              end
            end
          end
        end
        PH_KEY: begin
          res_valid       = 1'b1;
          res.kind        = KIND_KEY;
          res.byte_out    = in_data;
          res.position    = 32'(cur_shared) + emit_index;
          emit_index_next = emit_index + 32'd1;
          remaining_next  = remaining - KW'(1);
          if (remaining == KW'(1)) begin
            emit_index_next = '0;
            if (value_left != 32'd0) begin
              phase_next = PH_VALUE;
            end else begin
              phase_next     = PH_SHARED;
              res.record_end = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          res_valid       = 1'b1;
          res.kind        = KIND_VALUE;
          res.byte_out    = in_data;
          res.position    = emit_index;
          emit_index_next = emit_index + 32'd1;
          value_left_next = value_left - 32'd1;
          if (value_left == 32'd1) begin
            emit_index_next = '0;
            phase_next      = PH_SHARED;
            res.record_end  = 1'b1;
          end
        end
        default: begin
          phase_next = PH_SHARED;
        end
      endcase

      // An entry left open by the block's last byte is truncated.
      if (err == ERR_NONE && in_last &&
          (phase_next != PH_SHARED || varint_bytes_next != 3'd0)) begin
        err = ERR_TRUNCATED;
      end

      if (err != ERR_NONE) begin
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = err;
        res.record_end = 1'b1;
        res.block_end  = in_last;
        res_valid      = 1'b1;
        clear_all      = 1'b1;
      end else if (in_last) begin
        res.block_end = res_valid;
        clear_all     = 1'b1;
      end
    end

    if (clear_all) begin
      phase_next        = PH_SHARED;
      varint_acc_next   = '0;
      varint_bytes_next = '0;
      cur_shared_next   = '0;
      cur_suffix_next   = '0;
      remaining_next    = '0;
      value_left_next   = '0;
      emit_index_next   = '0;
      prev_key_len_next = '0;
      discarding_next   = !discarding && (err != ERR_NONE) && !in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SHARED;
      varint_acc   <= '0;
      varint_bytes <= '0;
      cur_shared   <= '0;
      cur_suffix   <= '0;
      remaining    <= '0;
      value_left   <= '0;
      emit_index   <= '0;
      prev_key_len <= '0;
      discarding   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      varint_acc   <= varint_acc_next;
      varint_bytes <= varint_bytes_next;
      cur_shared   <= cur_shared_next;
      cur_suffix   <= cur_suffix_next;
      remaining    <= remaining_next;
      value_left   <= value_left_next;
      emit_index   <= emit_index_next;
      prev_key_len <= prev_key_len_next;
      discarding   <= discarding_next;
    end
  end

endmodule

FILE: src/pkd_out_stage.sv
module pkd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  pkd_pkg::pkd_result_t res,
  input  logic                 m_tready,
  output logic                 out_valid,
  output pkd_pkg::pkd_result_t out_res
);
  import pkd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

FILE: src/prefix_key_entry_decoder.sv
// Each accepted byte is held in the input register; the parser step then loads its
// result item into the result register. Throughput: one input byte per cycle unless
// m_tready stalls the combinational parser step; each byte yields at most one item.
// Reset: rst is synchronous and active high; it empties both registers and returns
// the parser to the start of a block with a previous key length of zero.
module prefix_key_entry_decoder #(
  parameter int MAX_KEY = pkd_pkg::MAX_KEY_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte[7:0]
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // byte_out[7:0], position[39:8], shared_len[50:40],
                                  // suffix_len[61:51], value_len[93:62], is_delete[94],
                                  // error_code[97:95], record_end[98], zero fill
  output logic [1:0]   m_tuser,   // kind[1:0]
  output logic         m_tlast    // block_end
);
  import pkd_pkg::*;

  logic        in_valid;
  logic [7:0]  in_data;
  logic        in_last;
  logic        step;
  logic        res_valid;
  pkd_result_t res;
  pkd_result_t out_res;

  // The parser advances whenever a byte is held and the result register can take an item.
  assign step = in_valid && (!m_tvalid || m_tready);

  pkd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_data   (s_tdata),
    .s_last   (s_tlast),
    .step     (step),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_last  (in_last)
  );

  pkd_parser #(
    .MAX_KEY (MAX_KEY)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_data   (in_data),
    .in_last   (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  pkd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res       (res),
    .m_tready  (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res)
  );

  assign m_tdata = {5'b0, out_res.record_end, out_res.error_code, out_res.is_delete,
                    out_res.value_len, out_res.suffix_len, out_res.shared_len,
                    out_res.position, out_res.byte_out};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.block_end;

endmodule

FILE: bench/tb_prefix_key_entry_decoder.sv
`timescale 1ns / 100ps

module tb_prefix_key_entry_decoder;
  import pkd_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_BYTES = 1600;

  // Tracks the parser state of the block and holds the items it must emit.
  class decode_tracker;
    logic [2:0]  stage;
    logic [31:0] vint_val;
    int unsigned vint_cnt;
    int unsigned key_shared;
    int unsigned key_suffix;
    int unsigned last_key_len;
    int unsigned key_left;
    int unsigned out_idx;
    int unsigned val_left;
    bit          skipping;
    int unsigned live_bytes;
    int          errors;
    pkd_result_t due_items[$];

    function new();
      restart();
      live_bytes = 0;
      errors = 0;
    endfunction

    function void restart();
      stage = PH_SHARED;
      vint_val = '0;
      vint_cnt = 0;
      key_shared = 0;
      key_suffix = 0;
      last_key_len = 0;
      key_left = 0;
      out_idx = 0;
      val_left = 0;
      skipping = 0;
    endfunction

    function void note_byte(logic [7:0] d, logic l);
      pkd_result_t r;
      logic [2:0]  err;
      logic [31:0] v;
      bit          hit;
      r = '0;
      err = ERR_NONE;
      hit = 0;
      if (skipping) begin
        if (l) restart();
        return;
      end
      live_bytes++;
      case (stage)
        PH_SHARED, PH_SUFFIX, PH_VALCODE: begin
          // Bits of a fifth byte beyond bit 31 fall off the 32-bit accumulator.
          if (vint_cnt < 5) vint_val = vint_val | (32'(d[6:0]) << (7 * vint_cnt));
          vint_cnt++;
          if (d[7]) begin
            if (vint_cnt >= 5) err = ERR_VARINT;
          end else begin
            v = vint_val;
            vint_val = '0;
            vint_cnt = 0;
            if (stage == PH_SHARED) begin
              if (v > last_key_len) begin
                err = ERR_SHARED;
              end else begin
                key_shared = v;
                stage = PH_SUFFIX;
              end
            end else if (stage == PH_SUFFIX) begin
              if (64'(key_shared) + 64'(v) > 64'(MAX_KEY_DEFAULT)) begin
                err = ERR_KEY;
              end else begin
                key_suffix = v;
                stage = PH_VALCODE;
              end
            end else begin
              val_left = (v == 0) ? 0 : v - 1;
              r.kind = KIND_HEADER;
              r.shared_len = key_shared[10:0];
              r.suffix_len = key_suffix[10:0];
              r.value_len = val_left;
              r.is_delete = (v == 0);
              hit = 1;
              last_key_len = key_shared + key_suffix;
              key_left = key_suffix;
              out_idx = 0;
              if (key_left > 0) begin
                stage = PH_KEY;
              end else if (val_left > 0) begin
                stage = PH_VALUE;
              end else begin
                stage = PH_SHARED;
                r.record_end = 1'b1;
              end
            end
          end
        end
        PH_KEY: begin
          r.kind = KIND_KEY;
          r.byte_out = d;
          r.position = key_shared + out_idx;
          hit = 1;
          out_idx++;
          key_left--;
          if (key_left == 0) begin
            out_idx = 0;
            if (val_left > 0) begin
              stage = PH_VALUE;
            end else begin
              stage = PH_SHARED;
              r.record_end = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          r.kind = KIND_VALUE;
          r.byte_out = d;
          r.position = out_idx;
          hit = 1;
          out_idx++;
          val_left--;
          if (val_left == 0) begin
            out_idx = 0;
            stage = PH_SHARED;
            r.record_end = 1'b1;
          end
        end
        default: stage = PH_SHARED;
      endcase

      if (err == ERR_NONE && l && (stage != PH_SHARED || vint_cnt != 0)) err = ERR_TRUNCATED;

      if (err != ERR_NONE) begin
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = err;
        r.record_end = 1'b1;
        r.block_end = l;
        hit = 1;
        restart();
        skipping = !l;
      end else if (l) begin
        r.block_end = hit;
        restart();
      end
      if (hit) due_items.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, e, a);
        errors++;
      end
    endfunction

    function void check_item(logic [103:0] data, logic [1:0] user, logic lst);
      pkd_result_t e;
      if (due_items.size() == 0) begin
        $display("%0t ns: unexpected item, expected none actual kind %0d data %0h",
                 $time, user, data);
        errors++;
        return;
      end
      e = due_items.pop_front();
      compare("kind", 32'(e.kind), 32'(user));
      compare("byte_out", 32'(e.byte_out), 32'(data[7:0]));
      compare("position", e.position, data[39:8]);
      compare("shared_len", 32'(e.shared_len), 32'(data[50:40]));
      compare("suffix_len", 32'(e.suffix_len), 32'(data[61:51]));
      compare("value_len", e.value_len, data[93:62]);
      compare("is_delete", 32'(e.is_delete), 32'(data[94]));
      compare("error_code", 32'(e.error_code), 32'(data[97:95]));
      compare("record_end", 32'(e.record_end), 32'(data[98]));
      compare("zero fill", 32'h0, 32'(data[103:99]));
      compare("block_end", 32'(e.block_end), 32'(lst));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  decode_tracker tracker;
  logic [7:0]    blk[$];
  int unsigned   gen_prev;
  bit            calm = 0;
  int            rx_left = 0;
  bit            rx_on = 0;
  int            idle_cycles = 0;

  prefix_key_entry_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) tracker.check_item(m_tdata, m_tuser, m_tlast);
    if (rx_left == 0) begin
      if (calm || !rx_on) begin
        rx_on = 1;
        rx_left = calm ? 8 : $urandom_range(1, 20);
      end else begin
        rx_left = pick_gap();
        rx_on = (rx_left == 0);
      end
    end else begin
      rx_left--;
    end
    m_tready <= rx_on;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_prefix_key_entry_decoder: errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= l;
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.note_byte(d, l);
  endtask

  task automatic send_block();
    for (int i = 0; i < blk.size(); i++) send_byte(blk[i], i == blk.size() - 1);
  endtask

  // Stops sending until every pending item has been received.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.due_items.size() != 0);
  endtask

  // Base-128 encoding, optionally padded with redundant continuation bytes; a fifth byte may carry random high bits.
  function automatic void put_varint(int unsigned v, int pad);
    int          n;
    int          total;
    logic [7:0]  b;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    total = (n + pad > 5) ? 5 : n + pad;
    for (int i = 0; i < total; i++) begin
      b = 8'((v >> (7 * i)) & 32'h7f);
      if (i < total - 1) b[7] = 1'b1;
      if (i == 4 && $urandom_range(0, 1) == 1) b[6:4] = 3'($urandom_range(1, 7));
      blk.push_back(b);
    end
  endfunction

  function automatic int rand_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  function automatic void add_junk(int n);
    repeat (n) blk.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_good_entry();
    int unsigned sh;
    int unsigned su;
    int unsigned code;
    int          r;
    sh = $urandom_range(0, gen_prev);
    if ($urandom_range(0, 399) == 0) su = MAX_KEY_DEFAULT - sh;
    else if ($urandom_range(0, 9) == 0) su = $urandom_range(0, 40);
    else su = $urandom_range(0, 6);
    if (sh + su > MAX_KEY_DEFAULT) su = MAX_KEY_DEFAULT - sh;
    r = $urandom_range(0, 9);
    if (r < 3) code = 0;
    else if (r < 9) code = $urandom_range(1, 6);
    else code = $urandom_range(7, 40);
    put_varint(sh, rand_pad());
    put_varint(su, rand_pad());
    put_varint(code, rand_pad());
    add_junk(su);
    add_junk((code == 0) ? 0 : code - 1);
    gen_prev = sh + su;
  endfunction

  function automatic void make_block();
    int mode;
    int cut;
    blk.delete();
    gen_prev = 0;
    mode = $urandom_range(0, 99);
    repeat ($urandom_range(1, 6)) add_good_entry();
    if (mode < 80) begin
      return;
    end else if (mode < 86) begin
      if (blk.size() > 1) begin
        cut = $urandom_range(1, blk.size() - 1);
        while (blk.size() > cut) void'(blk.pop_back());
      end
    end else if (mode < 90) begin
      put_varint(gen_prev + $urandom_range(1, 300), rand_pad());
      add_junk($urandom_range(0, 6));
    end else if (mode < 94) begin
      cut = $urandom_range(0, gen_prev);
      put_varint(cut, rand_pad());
      put_varint(MAX_KEY_DEFAULT + 1 - cut + $urandom_range(0, 2000), 0);
      add_junk($urandom_range(0, 6));
    end else if (mode < 97) begin
      repeat (5) blk.push_back(8'($urandom_range(0, 255)) | 8'h80);
      add_junk($urandom_range(0, 6));
    end else begin
      blk.delete();
      add_junk($urandom_range(1, 16));
    end
  endfunction

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Smallest entry: empty key, delete marker.
    blk = {8'h00, 8'h00, 8'h00};
    send_block();
    // Two entries, the second reusing the whole previous key.
    blk = {8'h00, 8'h02, 8'h03, 8'hab, 8'hcd, 8'h00, 8'hff, 8'h02, 8'h01, 8'h01, 8'h7f};
    send_block();
    drain();
    // Padded zero, then a five-byte value code with dropped high bits, cut off.
    blk = {8'h80, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h5a};
    send_block();
    // Shared length beyond the previous key.
    blk = {8'h05, 8'h22};
    send_block();
    // Key too long reported on the last byte instead of truncation.
    blk = {8'h00, 8'h81, 8'h08};
    send_block();
    // Varint too long, then the last byte is swallowed.
    blk = {8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h33};
    send_block();
    // Block ends inside a varint.
    blk = {8'h85};
    send_block();
    drain();

    while (tracker.live_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      make_block();
      send_block();
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_prefix_key_entry_decoder: clean");
    end else begin
      $display("tb_prefix_key_entry_decoder: errors");
    end
    $finish;
  end

endmodule

FILE: prefix_key_entry_decoder.f
src/pkd_pkg.sv
src/pkd_in_stage.sv
src/pkd_parser.sv
src/pkd_out_stage.sv
src/prefix_key_entry_decoder.sv
bench/tb_prefix_key_entry_decoder.sv
